>>> hw/rtl/lcdmls_pkg.sv
// lcdmls_pkg: shared types and constants of the lcd mode and line sequencer
// mode codes, mode lengths, line limits and configuration register indexes
// no dependencies
package lcdmls_pkg;

  // display modes, in the encoding seen on the status port
  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM_SCAN = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LCD_ENABLE     = 3'd0,
    REG_LINE_COMPARE   = 3'd1,
    REG_HBLANK_IRQ_EN  = 3'd2,
    REG_VBLANK_IRQ_EN  = 3'd3,
    REG_OAM_IRQ_EN     = 3'd4,
    REG_COMPARE_IRQ_EN = 3'd5
  } reg_idx_e;

  localparam int unsigned CountW    = 11;
  localparam int unsigned LineW     = 8;
  localparam int unsigned ElapsedW  = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [LineW-1:0] LineVblankStart = 8'd144;
  localparam logic [LineW-1:0] LineWrap        = 8'd154;

  // lowest value the countdown may take
  localparam logic signed [CountW:0] CountMin = -12'sd1024;

  // cycle count of each mode, in countdown format
  function automatic logic signed [CountW-1:0] mode_len(mode_e m);
    logic signed [CountW-1:0] len;
    len = 11'sd0;
    unique case (m)
      MODE_HBLANK:   len = 11'sd204;
      MODE_VBLANK:   len = 11'sd456;
      MODE_OAM_SCAN: len = 11'sd80;
      MODE_TRANSFER: len = 11'sd172;
      default:       len = 11'sd0;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/lcd_mode_line_sequencer_top.sv
// lcd_mode_line_sequencer_top: lcd mode and scan line sequencer
// one input register stage, one step of the mode machine, one result register
// depends on lcdmls_pkg
//
// Usage:
//   Each request on the input channel (in_valid_i / in_ready_o) carries the
//   clock cycles elapsed since the previous request. Every request yields
//   exactly one result on the output channel (out_valid_o / out_ready_i):
//   mode, line, coincidence, interrupt pulses, render request and frame done.
//   Configuration registers are written through cfg_we_i / cfg_index_i /
//   cfg_data_i; the user must write them only while no request is in flight,
//   as the block does not enforce this. Writes beyond index 5 are dropped.
//   A request passes the input register, then the result register. While the
//   receiver keeps out_ready_i high, throughput is one request per cycle; the
//   countdown, mode and line registers are updated by a single short step
//   between the two register stages, so consecutive requests see each other's
//   state without bubbles.
//   Reset clears the countdown, sets mode hblank and line 0, turns the
//   display on and clears the compare value and interrupt enables.
//   When the receiver stalls, the result register holds and the input stage
//   keeps one more request; in_ready_o drops once both are full.
module lcd_mode_line_sequencer_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [lcdmls_pkg::ElapsedW-1:0]       elapsed_cycles_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            mode_o,
  output logic [lcdmls_pkg::LineW-1:0]          line_o,
  output logic                                  coincidence_o,
  output logic                                  vblank_irq_o,
  output logic                                  stat_irq_o,
  output logic                                  render_request_o,
  output logic [lcdmls_pkg::LineW-1:0]          render_line_o,
  output logic                                  frame_done_o,
  // configuration port
  input  logic                                  cfg_we_i,
  input  logic [lcdmls_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [lcdmls_pkg::CfgDataW-1:0]       cfg_data_i
);

  // configuration registers
  logic                             lcd_enable_q;
  logic [lcdmls_pkg::LineW-1:0]     line_compare_q;
  logic                             hblank_irq_en_q;
  logic                             vblank_irq_en_q;
  logic                             oam_irq_en_q;
  logic                             compare_irq_en_q;

  // sequencer state
  logic signed [lcdmls_pkg::CountW-1:0] countdown_q, countdown_d;
  lcdmls_pkg::mode_e                    mode_q, mode_d;
  logic [lcdmls_pkg::LineW-1:0]         line_q, line_d;

  // input stage
  logic                                 s1_valid_q;
  logic [lcdmls_pkg::ElapsedW-1:0]      s1_elapsed_q;

  // result stage
  logic                                 out_valid_q;
  logic [1:0]                           res_mode_q, res_mode_d;
  logic [lcdmls_pkg::LineW-1:0]         res_line_q;
  logic                                 res_coin_q, res_coin_d;
  logic                                 res_vblank_irq_q, res_vblank_irq_d;
  logic                                 res_stat_irq_q, res_stat_irq_d;
  logic                                 res_render_q, res_render_d;
  logic [lcdmls_pkg::LineW-1:0]         res_render_line_q, res_render_line_d;
  logic                                 res_frame_done_q, res_frame_done_d;

  // handshake
  logic out_free;
  logic step_go;
  logic in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step_go    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_enable_q     <= 1'b1;
      line_compare_q   <= '0;
      hblank_irq_en_q  <= 1'b0;
      vblank_irq_en_q  <= 1'b0;
      oam_irq_en_q     <= 1'b0;
      compare_irq_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lcdmls_pkg::REG_LCD_ENABLE:     lcd_enable_q     <= cfg_data_i[0];
        lcdmls_pkg::REG_LINE_COMPARE:   line_compare_q   <= cfg_data_i;
        lcdmls_pkg::REG_HBLANK_IRQ_EN:  hblank_irq_en_q  <= cfg_data_i[0];
        lcdmls_pkg::REG_VBLANK_IRQ_EN:  vblank_irq_en_q  <= cfg_data_i[0];
        lcdmls_pkg::REG_OAM_IRQ_EN:     oam_irq_en_q     <= cfg_data_i[0];
        lcdmls_pkg::REG_COMPARE_IRQ_EN: compare_irq_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_elapsed_q <= elapsed_cycles_i;
    end
  end

  // one step of the mode machine
  always_comb begin
    logic signed [lcdmls_pkg::CountW:0]   diff;
    logic signed [lcdmls_pkg::CountW-1:0] sat;
    logic [lcdmls_pkg::LineW-1:0]         line_inc;
    logic                                 mode_entry;
    logic                                 line_adv;
    logic                                 mode_irq;

    countdown_d       = countdown_q;
    mode_d            = mode_q;
    line_d            = line_q;
    res_vblank_irq_d  = 1'b0;
    res_stat_irq_d    = 1'b0;
    res_render_d      = 1'b0;
    res_render_line_d = '0;
    res_frame_done_d  = 1'b0;
    mode_entry        = 1'b0;
    line_adv          = 1'b0;
    mode_irq          = 1'b0;

    diff = {countdown_q[lcdmls_pkg::CountW-1], countdown_q}
         - $signed({4'b0000, s1_elapsed_q});
    if (diff < lcdmls_pkg::CountMin) begin
      sat = lcdmls_pkg::CountMin[lcdmls_pkg::CountW-1:0];
    end else begin
      sat = diff[lcdmls_pkg::CountW-1:0];
    end
    line_inc = 8'(line_q + 8'd1);

    if (lcd_enable_q) begin
      countdown_d = sat;
      if (sat[lcdmls_pkg::CountW-1] || sat == '0) begin
        unique case (mode_q)
          lcdmls_pkg::MODE_HBLANK: begin
            mode_d = (line_q == lcdmls_pkg::LineVblankStart) ?
                     lcdmls_pkg::MODE_VBLANK : lcdmls_pkg::MODE_OAM_SCAN;
            mode_entry = 1'b1;
          end
          lcdmls_pkg::MODE_VBLANK: begin
            line_adv = 1'b1;
            if (line_inc == lcdmls_pkg::LineWrap) begin
              line_d           = '0;
              res_frame_done_d = 1'b1;
              mode_d           = lcdmls_pkg::MODE_OAM_SCAN;
              mode_entry       = 1'b1;
            end else begin
              line_d = line_inc;
            end
          end
          lcdmls_pkg::MODE_OAM_SCAN: begin
            mode_d = lcdmls_pkg::MODE_TRANSFER;
          end
          default: begin
            res_render_d      = 1'b1;
            res_render_line_d = line_q;
            line_d            = line_inc;
            mode_d            = lcdmls_pkg::MODE_HBLANK;
            mode_entry        = 1'b1;
            line_adv          = 1'b1;
          end
        endcase
        countdown_d = 11'(sat + lcdmls_pkg::mode_len(mode_d));

        // interrupt enable of the entered mode
        case (mode_d)
          lcdmls_pkg::MODE_HBLANK:   mode_irq = hblank_irq_en_q;
          lcdmls_pkg::MODE_VBLANK:   mode_irq = vblank_irq_en_q;
          lcdmls_pkg::MODE_OAM_SCAN: mode_irq = oam_irq_en_q;
          default:                   mode_irq = 1'b0;
        endcase
        res_vblank_irq_d = mode_entry && (mode_d == lcdmls_pkg::MODE_VBLANK);
        res_stat_irq_d   = (mode_entry && mode_irq)
                        || (line_adv && compare_irq_en_q && (line_d == line_compare_q));
      end
    end

    res_mode_d = mode_d;
    res_coin_d = (line_d == line_compare_q);
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      mode_q      <= lcdmls_pkg::MODE_HBLANK;
      line_q      <= '0;
    end else if (step_go) begin
      countdown_q <= countdown_d;
      mode_q      <= mode_d;
      line_q      <= line_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      res_mode_q        <= res_mode_d;
      res_line_q        <= line_d;
      res_coin_q        <= res_coin_d;
      res_vblank_irq_q  <= res_vblank_irq_d;
      res_stat_irq_q    <= res_stat_irq_d;
      res_render_q      <= res_render_d;
      res_render_line_q <= res_render_line_d;
      res_frame_done_q  <= res_frame_done_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_o           = res_mode_q;
  assign line_o           = res_line_q;
  assign coincidence_o    = res_coin_q;
  assign vblank_irq_o     = res_vblank_irq_q;
  assign stat_irq_o       = res_stat_irq_q;
  assign render_request_o = res_render_q;
  assign render_line_o    = res_render_line_q;
  assign frame_done_o     = res_frame_done_q;

  // line counter never leaves the visible plus vblank range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < lcdmls_pkg::LineWrap)
    else $error("line counter out of range");

  // a render request always comes with the entry into hblank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && render_request_o |-> mode_o == lcdmls_pkg::MODE_HBLANK)
    else $error("render request outside hblank entry");

  // frame wrap lands on line 0 in oam scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |->
      line_o == '0 && mode_o == lcdmls_pkg::MODE_OAM_SCAN)
    else $error("frame done without wrap to oam scan");

  // vblank interrupt only on entering vblank at the first vblank line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vblank_irq_o |->
      mode_o == lcdmls_pkg::MODE_VBLANK && line_o == lcdmls_pkg::LineVblankStart)
    else $error("vblank interrupt outside vblank entry");

  // a stepped request always reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_valid_q)
    else $error("stepped request lost");

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench of the lcd mode and line sequencer
// predicts mode, line, coincidence, pulses and render requests per tick request
// depends on lcdmls_pkg and lcd_mode_line_sequencer_top
`timescale 1ns / 1ps

module tb_top;

  // mode timing of the scan sequence, kept apart from the rtl package
  localparam int          CountBits   = 11;
  localparam int          CountFloor  = -1024;
  localparam int          HblankLen   = 204;
  localparam int          VblankLen   = 456;
  localparam int          OamLen      = 80;
  localparam int          TransferLen = 172;
  localparam logic [7:0]  VblankLine  = 8'd144;
  localparam logic [7:0]  LastLine    = 8'd153;
  localparam logic [7:0]  WrapLine    = 8'd154;
  // register indexes past the last register, writes there are dropped
  localparam logic [lcdmls_pkg::CfgIndexW-1:0] RegSpareLo = 3'd6;
  localparam logic [lcdmls_pkg::CfgIndexW-1:0] RegSpareHi = 3'd7;
  // idle cycles allowed: above the longest receiver hold (HoldCycles),
  // the sender gaps and a configuration pause
  localparam int          StallLimit  = 2000;
  localparam int          HoldCycles  = 400;
  localparam int          ActiveTicks = 1000;

  typedef struct packed {
    lcdmls_pkg::mode_e mode;
    logic [7:0]        line;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_request;
    logic [7:0]        render_line;
    logic              frame_done;
  } lcd_status_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [lcdmls_pkg::ElapsedW-1:0]  elapsed_cycles_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [1:0]                       mode_o;
  logic [lcdmls_pkg::LineW-1:0]     line_o;
  logic                             coincidence_o;
  logic                             vblank_irq_o;
  logic                             stat_irq_o;
  logic                             render_request_o;
  logic [lcdmls_pkg::LineW-1:0]     render_line_o;
  logic                             frame_done_o;
  logic                             cfg_we_i;
  logic [lcdmls_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [lcdmls_pkg::CfgDataW-1:0]  cfg_data_i;

  // predicted sequencer state and register copies
  logic signed [CountBits-1:0] scan_count;
  lcdmls_pkg::mode_e           scan_mode;
  logic [7:0]                  scan_line;
  logic                        cfg_lcd_enable;
  logic [7:0]                  cfg_line_compare;
  logic                        cfg_hblank_irq;
  logic                        cfg_vblank_irq;
  logic                        cfg_oam_irq;
  logic                        cfg_compare_irq;

  logic [7:0]   tick_q[$];
  lcd_status_t  status_q[$];
  lcd_status_t  got_status;
  lcd_status_t  want_status;
  int           n_pushed;
  int           n_accepted;
  int           n_results;
  int           err_count;
  int           idle_cycles;
  int           active_ticks;
  int           burst_left;
  int           gap_left;
  int           hold_left;
  int           style_left;
  int           pat_idx;
  logic [1:0]   rx_style;
  logic [7:0]   rx_pattern;
  logic         hold_done;
  logic         in_fire;

  lcd_mode_line_sequencer_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .elapsed_cycles_i (elapsed_cycles_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_o           (mode_o),
    .line_o           (line_o),
    .coincidence_o    (coincidence_o),
    .vblank_irq_o     (vblank_irq_o),
    .stat_irq_o       (stat_irq_o),
    .render_request_o (render_request_o),
    .render_line_o    (render_line_o),
    .frame_done_o     (frame_done_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock and known input levels from time zero
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    elapsed_cycles_i = '0;
    out_ready_i      = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    forever #5 clk_i = ~clk_i;
  end

  // one tick of the mode machine, updates the predicted state
  function automatic lcd_status_t step_sequencer(logic [7:0] elapsed);
    lcd_status_t       s;
    int                cnt;
    lcdmls_pkg::mode_e nxt;
    logic              entered;
    logic              advanced;
    s        = '0;
    entered  = 1'b0;
    advanced = 1'b0;
    if (cfg_lcd_enable) begin
      cnt = int'(scan_count) - int'(elapsed);
      if (cnt < CountFloor) cnt = CountFloor;
      if (cnt <= 0) begin
        nxt = scan_mode;
        case (scan_mode)
          lcdmls_pkg::MODE_HBLANK: begin
            nxt = (scan_line == VblankLine) ? lcdmls_pkg::MODE_VBLANK
                                            : lcdmls_pkg::MODE_OAM_SCAN;
            entered = 1'b1;
          end
          lcdmls_pkg::MODE_VBLANK: begin
            scan_line = scan_line + 8'd1;
            if (scan_line == WrapLine) begin
              scan_line    = '0;
              s.frame_done = 1'b1;
              nxt          = lcdmls_pkg::MODE_OAM_SCAN;
              entered      = 1'b1;
            end
            advanced = 1'b1;
          end
          lcdmls_pkg::MODE_OAM_SCAN: nxt = lcdmls_pkg::MODE_TRANSFER;
          default: begin
            s.render_request = 1'b1;
            s.render_line    = scan_line;
            scan_line        = scan_line + 8'd1;
            nxt              = lcdmls_pkg::MODE_HBLANK;
            entered          = 1'b1;
            advanced         = 1'b1;
          end
        endcase
        scan_mode = nxt;
        case (nxt)
          lcdmls_pkg::MODE_HBLANK:   cnt += HblankLen;
          lcdmls_pkg::MODE_VBLANK:   cnt += VblankLen;
          lcdmls_pkg::MODE_OAM_SCAN: cnt += OamLen;
          default:                   cnt += TransferLen;
        endcase
        if (entered && nxt == lcdmls_pkg::MODE_VBLANK) s.vblank_irq = 1'b1;
        if (entered && ((nxt == lcdmls_pkg::MODE_HBLANK && cfg_hblank_irq) ||
                        (nxt == lcdmls_pkg::MODE_VBLANK && cfg_vblank_irq) ||
                        (nxt == lcdmls_pkg::MODE_OAM_SCAN && cfg_oam_irq)))
          s.stat_irq = 1'b1;
        if (advanced && scan_line == cfg_line_compare && cfg_compare_irq)
          s.stat_irq = 1'b1;
      end
      scan_count = CountBits'(cnt);
    end
    s.mode        = scan_mode;
    s.line        = scan_line;
    s.coincidence = (scan_line == cfg_line_compare);
    return s;
  endfunction

  // tick driver: bursts of requests with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() > 0) begin
        in_valid_i       <= 1'b1;
        elapsed_cycles_i <= tick_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25)
                                                    : $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: changing stall styles plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && n_results >= 150 && tick_q.size() > 10) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   <= 2'($urandom_range(0, 3));
        rx_pattern <= 8'($urandom);
        style_left <= $urandom_range(20, 120);
      end else begin
        style_left <= style_left - 1;
      end
      pat_idx <= (pat_idx + 1) % 8;
      case (rx_style)
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
        2'd2:    out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= rx_pattern[3'(pat_idx)];
      endcase
    end
  end

  // request and result monitor
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      status_q.push_back(step_sequencer(elapsed_cycles_i));
      n_accepted <= n_accepted + 1;
    end
    if (out_valid_o && out_ready_i) begin
      n_results <= n_results + 1;
      got_status = '{mode: lcdmls_pkg::mode_e'(mode_o), line: line_o,
                     coincidence: coincidence_o,
                     vblank_irq: vblank_irq_o, stat_irq: stat_irq_o,
                     render_request: render_request_o, render_line: render_line_o,
                     frame_done: frame_done_o};
      if (status_q.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result: mode %0d line %0d", mode_o, line_o);
        err_count <= err_count + 1;
      end else begin
        want_status = status_q.pop_front();
        if (got_status !== want_status) begin
          if (err_count < 10)
            $display({"mismatch at result %0d: mode/line/coin/vbl/stat/rreq/rline/fdone",
                      " exp %0d %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d %0d"},
                     n_results, want_status.mode, want_status.line,
                     want_status.coincidence, want_status.vblank_irq,
                     want_status.stat_irq, want_status.render_request,
                     want_status.render_line, want_status.frame_done,
                     got_status.mode, got_status.line, got_status.coincidence,
                     got_status.vblank_irq, got_status.stat_irq,
                     got_status.render_request, got_status.render_line,
                     got_status.frame_done);
          err_count <= err_count + 1;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog on cycles without any accepted request or result
  initial begin
    while (idle_cycles < StallLimit) @(negedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // register write, mirrored into the predictor once it has landed
  task automatic write_reg(input logic [lcdmls_pkg::CfgIndexW-1:0] idx,
                           input logic [lcdmls_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      lcdmls_pkg::REG_LCD_ENABLE:     cfg_lcd_enable   = val[0];
      lcdmls_pkg::REG_LINE_COMPARE:   cfg_line_compare = val;
      lcdmls_pkg::REG_HBLANK_IRQ_EN:  cfg_hblank_irq   = val[0];
      lcdmls_pkg::REG_VBLANK_IRQ_EN:  cfg_vblank_irq   = val[0];
      lcdmls_pkg::REG_OAM_IRQ_EN:     cfg_oam_irq      = val[0];
      lcdmls_pkg::REG_COMPARE_IRQ_EN: cfg_compare_irq  = val[0];
      default: ;
    endcase
  endtask

  // one bit registers get random upper data bits, only bit 0 counts
  task automatic write_flag(input logic [lcdmls_pkg::CfgIndexW-1:0] idx, input logic bit0);
    write_reg(idx, {7'($urandom), bit0});
  endtask

  task automatic load_random_config();
    logic [7:0] cmp;
    case ($urandom_range(0, 4))
      0:       cmp = 8'h00;
      1:       cmp = 8'hFF;
      2:       cmp = VblankLine;
      3:       cmp = LastLine;
      default: cmp = 8'($urandom_range(0, LastLine));
    endcase
    write_flag(lcdmls_pkg::REG_LCD_ENABLE, $urandom_range(0, 7) != 0);
    write_reg(lcdmls_pkg::REG_LINE_COMPARE, cmp);
    write_flag(lcdmls_pkg::REG_HBLANK_IRQ_EN, 1'($urandom_range(0, 1)));
    write_flag(lcdmls_pkg::REG_VBLANK_IRQ_EN, 1'($urandom_range(0, 1)));
    write_flag(lcdmls_pkg::REG_OAM_IRQ_EN, 1'($urandom_range(0, 1)));
    write_flag(lcdmls_pkg::REG_COMPARE_IRQ_EN, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? RegSpareHi : RegSpareLo, 8'($urandom));
  endtask

  task automatic queue_tick(input logic [7:0] v);
    tick_q.push_back(v);
    n_pushed++;
  endtask

  // all requests accepted and all results in, then a short settle
  task automatic wait_drained();
    while (n_accepted != n_pushed || status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    int n;
    scan_count       = '0;
    scan_mode        = lcdmls_pkg::MODE_HBLANK;
    scan_line        = '0;
    cfg_lcd_enable   = 1'b1;
    cfg_line_compare = '0;
    cfg_hblank_irq   = 1'b0;
    cfg_vblank_irq   = 1'b0;
    cfg_oam_irq      = 1'b0;
    cfg_compare_irq  = 1'b0;
    n_pushed = 0; n_accepted = 0; n_results = 0; err_count = 0; idle_cycles = 0;
    burst_left = 0; gap_left = 0; hold_left = 0; hold_done = 1'b0;
    style_left = 0; pat_idx = 0; rx_style = '0; rx_pattern = '0; in_fire = 1'b0;
    active_ticks = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zero tick forces a transition, long ticks saturate
    @(posedge clk_i);
    queue_tick(8'd0);
    repeat (12) queue_tick(8'd255);
    queue_tick(8'd1);
    queue_tick(8'd0);
    wait_drained();

    // display off: ticks leave the state alone
    write_flag(lcdmls_pkg::REG_LCD_ENABLE, 1'b0);
    @(posedge clk_i);
    queue_tick(8'd0);
    queue_tick(8'd255);
    queue_tick(8'd128);
    wait_drained();

    // every interrupt enabled, compare value at its top
    write_flag(lcdmls_pkg::REG_LCD_ENABLE, 1'b1);
    write_reg(lcdmls_pkg::REG_LINE_COMPARE, 8'hFF);
    write_flag(lcdmls_pkg::REG_HBLANK_IRQ_EN, 1'b1);
    write_flag(lcdmls_pkg::REG_VBLANK_IRQ_EN, 1'b1);
    write_flag(lcdmls_pkg::REG_OAM_IRQ_EN, 1'b1);
    write_flag(lcdmls_pkg::REG_COMPARE_IRQ_EN, 1'b1);
    write_reg(RegSpareLo, 8'hFF);
    @(posedge clk_i);
    queue_tick(8'h55);
    queue_tick(8'hAA);
    queue_tick(8'd1);
    queue_tick(8'd2);
    queue_tick(8'd4);
    queue_tick(8'd8);
    queue_tick(8'd16);
    wait_drained();

    // random phases, each under a fresh register setting
    while (active_ticks < ActiveTicks) begin
      load_random_config();
      n = $urandom_range(40, 160);
      @(posedge clk_i);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       queue_tick(8'($urandom_range(0, 15)));
          1:       queue_tick(8'd255);
          2:       queue_tick(8'($urandom_range(200, 255)));
          default: queue_tick(8'($urandom_range(0, 255)));
        endcase
      end
      if (cfg_lcd_enable) active_ticks += n;
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (err_count == 0 && status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lcdmls_pkg.sv
hw/rtl/lcd_mode_line_sequencer_top.sv
tb/sv/tb_top.sv
